[src/rpn_pkg.sv]
// Package: sizes, character codes and result kinds of the RPN stack calculator.
package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef enum logic [1:0] {
    KIND_PRINT     = 2'd0,
    KIND_UNDERFLOW = 2'd1,
    KIND_OVERFLOW  = 2'd2
  } kind_t;

  // Work left for the cycle after the stack read.
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_LOAD = 2'd2
  } op_t;

endpackage

[src/rpn_in_if.sv]
// Interface: character channel (valid, ready, character and end-of-line mark).
interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

[src/rpn_out_if.sv]
// Interface: result channel (valid, ready, value and kind).
interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  rpn_pkg::kind_t     kind;

  modport source (output valid, output value, output kind, input ready);
  modport sink   (input valid, input value, input kind, output ready);
endinterface

[src/rpn_stack_calculator.sv]
// Top level: reverse Polish add/subtract calculator over a one-port stack memory.
//
// chars carries one ASCII character per beat, with end_of_line on the last one of a
// line. results carries one beat per printed value ('.') or per error: kind is
// KIND_PRINT with the popped value, or KIND_UNDERFLOW / KIND_OVERFLOW with value 0.
// Digits build a pending number; any other character pushes it first, then applies
// its operator. A line end clears the stack and the pending number.
//
// Throughput: one character per cycle while the result queue has room, except '+',
// '-' or '.' that follow no digits and leave entries below the top; chars.ready then
// drops until the entry under the top has come out of the stack memory (one port,
// registered read), so the next character sees the new top. The top entry lives in a
// register, so a number followed directly by an operator needs no memory read.
// A result is registered into the queue and shows once older results are taken.
//
// Results sit in a two-entry queue, so characters keep flowing while one result
// waits; chars.ready drops only when both entries are full or a read is in flight.
// Reset (rst, synchronous) empties the stack, the pending number and the queue; the
// memory itself needs no clearing, only entries below the depth are ever read.
module rpn_stack_calculator (
  input  logic clk,
  input  logic rst,
  rpn_in_if.sink    chars,
  rpn_out_if.source results
);
  import rpn_pkg::*;

  // Stack memory: positions 0 .. depth-2; position depth-1 is the tos register.
  logic [31:0]        mem [STACK_DEPTH];
  logic [31:0]        rd_data;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [31:0]        mem_wdata;

  logic [DEPTH_W-1:0] depth, depth_next;
  logic [31:0]        tos, tos_next;
  logic [31:0]        pending, pending_next;
  logic               have_digits, have_digits_next;
  logic               busy, busy_next;
  op_t                busy_op, busy_op_next;

  logic               accept;
  logic               is_digit;
  logic               pushed;
  logic               ovf;
  logic [DEPTH_W-1:0] d1;
  logic [31:0]        cur_top;
  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;

  logic               emit;
  logic [31:0]        emit_value;
  kind_t              emit_kind;

  // Result queue, entry 0 is the head.
  logic [1:0]         q_cnt;
  logic [1:0]         q_after_pop;
  logic [31:0]        q_value [2];
  kind_t              q_kind  [2];
  logic               q_pop;

  assign chars.ready = !busy && (q_cnt != 2'd2);
  assign accept      = chars.valid && chars.ready;
  assign depth_m1    = depth - DEPTH_W'(1);
  assign depth_m2    = depth - DEPTH_W'(2);

  always_comb begin
    is_digit         = chars.char_code inside {[CH_ZERO:CH_NINE]};
    depth_next       = depth;
    tos_next         = tos;
    pending_next     = pending;
    have_digits_next = have_digits;
    busy_next        = 1'b0;
    busy_op_next     = busy_op;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_addr         = depth_m1[ADDR_W-1:0];
    mem_wdata        = tos;
    emit             = 1'b0;
    emit_value       = 32'd0;
    emit_kind        = KIND_PRINT;
    pushed           = 1'b0;
    ovf              = 1'b0;
    d1               = depth;
    cur_top          = tos;

    // Finish an operator whose lower operand was read last cycle.
    if (busy) begin
      case (busy_op)
        OP_ADD:  tos_next = rd_data + tos;
        OP_SUB:  tos_next = rd_data - tos;
        OP_LOAD: tos_next = rd_data;
        default: tos_next = tos;
      endcase
    end

    if (accept) begin
      if (is_digit) begin
        pending_next     = (pending << 3) + (pending << 1)
                         + {24'd0, chars.char_code - CH_ZERO};
        have_digits_next = 1'b1;
      end else begin
        pending_next     = 32'd0;
        have_digits_next = 1'b0;

        // Push the pending number: spill the old top into memory.
        if (have_digits) begin
          if (depth == DEPTH_FULL) begin
            ovf       = 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_OVERFLOW;
          end else begin
            pushed  = 1'b1;
            mem_we  = (depth != '0);
            d1      = depth + DEPTH_W'(1);
            cur_top = pending;
          end
        end
        depth_next = d1;
        tos_next   = cur_top;

        if (!ovf) begin
          if (chars.char_code == CH_PLUS || chars.char_code == CH_MINUS) begin
            if (d1 < DEPTH_W'(2)) begin
              emit      = 1'b1;
              emit_kind = KIND_UNDERFLOW;
            end else if (pushed) begin
              // Operands are the old top and the fresh number: no read needed.
              depth_next = depth;
              tos_next   = (chars.char_code == CH_PLUS) ? tos + pending : tos - pending;
            end else begin
              mem_re       = 1'b1;
              mem_addr     = depth_m2[ADDR_W-1:0];
              busy_next    = 1'b1;
              busy_op_next = (chars.char_code == CH_PLUS) ? OP_ADD : OP_SUB;
              depth_next   = depth_m1;
            end
          end else if (chars.char_code == CH_DOT) begin
            if (d1 == '0) begin
              emit      = 1'b1;
              emit_kind = KIND_UNDERFLOW;
            end else begin
              emit       = 1'b1;
              emit_value = cur_top;
              depth_next = d1 - DEPTH_W'(1);
              if (pushed) begin
                tos_next = tos;
              end else if (depth >= DEPTH_W'(2)) begin
                // Refill the top from the entry below it.
                mem_re       = 1'b1;
                mem_addr     = depth_m2[ADDR_W-1:0];
                busy_next    = 1'b1;
                busy_op_next = OP_LOAD;
              end
            end
          end
        end
      end

      // Line end: drop everything after the character is handled.
      if (chars.end_of_line) begin
        depth_next       = '0;
        pending_next     = 32'd0;
        have_digits_next = 1'b0;
        busy_next        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth       <= '0;
      pending     <= 32'd0;
      have_digits <= 1'b0;
      busy        <= 1'b0;
      busy_op     <= OP_LOAD;
    end else begin
      depth       <= depth_next;
      pending     <= pending_next;
      have_digits <= have_digits_next;
      busy        <= busy_next;
      busy_op     <= busy_op_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
  end

  // Result queue: advance the head on a taken beat, append behind what remains.
  assign q_pop       = results.valid && results.ready;
  assign q_after_pop = q_cnt - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_after_pop + {1'b0, emit};
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !q_after_pop[0]) begin
      q_value[0] <= emit_value;
      q_kind[0]  <= emit_kind;
    end else if (q_pop) begin
      q_value[0] <= q_value[1];
      q_kind[0]  <= q_kind[1];
    end
    if (emit && q_after_pop[0]) begin
      q_value[1] <= emit_value;
      q_kind[1]  <= emit_kind;
    end
  end

  assign results.valid = (q_cnt != 2'd0);
  assign results.value = q_value[0];
  assign results.kind  = q_kind[0];

  // A read is in flight only right after an accepted character.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(accept))
    else $error("stack read pending without an accepted character");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_FULL)
    else $error("stack depth beyond capacity");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("result queue overrun");

  a_digit_keeps_depth: assert property (@(posedge clk) disable iff (rst)
    accept && is_digit && !chars.end_of_line |=> $stable(depth))
    else $error("digit changed the stack depth");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    accept && chars.end_of_line |=> depth == '0 && !have_digits && !busy)
    else $error("line end left stack state behind");

endmodule

[tb/tb_rpn_stack_calculator.sv]
// Testbench for the RPN stack calculator: a mirrored stack predicts each result beat.
module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  // Characters that have no code in the package.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam int RANDOM_CHARS = 1600;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_LIMIT  = 50000;

  typedef struct packed {
    logic signed [31:0] value;
    kind_t              kind;
  } calc_result_t;

  // Mirror of the calculator: stack, pending number and the results it owes.
  class rpn_checker;
    logic [31:0]  stack_mem [STACK_DEPTH];
    int unsigned  depth;
    logic [31:0]  pending_num;
    bit           have_digits;
    calc_result_t due_results[$];
    int errors, chars_seen, lines_seen, prints, underflows, overflows;

    function new();
      depth       = 0;
      pending_num = '0;
      have_digits = 1'b0;
      errors      = 0;
      chars_seen  = 0;
      lines_seen  = 0;
      prints      = 0;
      underflows  = 0;
      overflows   = 0;
    endfunction

    // Apply one accepted character and queue the result it causes, if any.
    function void note_char(logic [7:0] ch, logic eol);
      calc_result_t r;
      bit           emit;
      bit           skip_op;
      logic [31:0]  lhs, rhs;
      emit    = 1'b0;
      skip_op = 1'b0;
      r.value = '0;
      r.kind  = KIND_PRINT;
      chars_seen++;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        pending_num = pending_num * 32'd10 + 32'(ch - CH_ZERO);
        have_digits = 1'b1;
      end else begin
        if (have_digits) begin
          have_digits = 1'b0;
          if (depth >= STACK_DEPTH) begin
            emit    = 1'b1;
            skip_op = 1'b1;
            r.kind  = KIND_OVERFLOW;
          end else begin
            stack_mem[depth] = pending_num;
            depth++;
          end
          pending_num = '0;
        end
        if (!skip_op) begin
          if (ch == CH_PLUS || ch == CH_MINUS) begin
            if (depth < 2) begin
              emit   = 1'b1;
              r.kind = KIND_UNDERFLOW;
            end else begin
              rhs = stack_mem[depth-1];
              lhs = stack_mem[depth-2];
              depth--;
              stack_mem[depth-1] = (ch == CH_PLUS) ? lhs + rhs : lhs - rhs;
            end
          end else if (ch == CH_DOT) begin
            if (depth == 0) begin
              emit   = 1'b1;
              r.kind = KIND_UNDERFLOW;
            end else begin
              depth--;
              emit    = 1'b1;
              r.value = stack_mem[depth];
            end
          end
        end
      end
      if (eol) begin
        depth       = 0;
        pending_num = '0;
        have_digits = 1'b0;
        lines_seen++;
      end
      if (emit) begin
        due_results.push_back(r);
        case (r.kind)
          KIND_PRINT:     prints++;
          KIND_UNDERFLOW: underflows++;
          default:        overflows++;
        endcase
      end
    endfunction

    function void check_result(logic signed [31:0] value, kind_t kind);
      calc_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result beat: value %0d kind %0d", value, kind);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (value !== want.value) begin
        $error("field value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (kind !== want.kind) begin
        $error("field kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpn_in_if  chars_if();
  rpn_out_if results_if();

  rpn_stack_calculator dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rpn_checker  calc;
  logic [7:0]  line_chars[$];
  bit          tx_calm;
  bit          rx_calm;
  int          rx_hold_cycles;
  int          rand_sent;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Offer one character and hold it until the block takes the beat.
  task automatic send_char(logic [7:0] ch, logic eol);
    int gap;
    gap = tx_calm ? 0 : idle_span();
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.char_code   <= ch;
    chars_if.end_of_line <= eol;
    do @(posedge clk); while (!chars_if.ready);
    calc.note_char(ch, eol);
  endtask

  task automatic send_text(string s, bit eol_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eol_last && (i == s.len() - 1));
  endtask

  // Send the assembled line, flagging its last character as the line end.
  task automatic send_line();
    for (int i = 0; i < line_chars.size(); i++)
      send_char(line_chars[i], i == line_chars.size() - 1);
    rand_sent += line_chars.size();
    line_chars.delete();
  endtask

  // Drop valid and hold until every owed result has been taken, or the limit runs out.
  task automatic wait_drain(int limit);
    int waited;
    waited = 0;
    chars_if.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (calc.due_results.size() > 0 && waited < limit);
  endtask

  task automatic add_number(int max_digits);
    int nd;
    nd = $urandom_range(1, max_digits);
    repeat (nd) line_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Space most of the time, otherwise any byte that is neither digit nor operator.
  function automatic logic [7:0] separator();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0 || (c >= CH_ZERO && c <= CH_NINE) ||
        c == CH_PLUS || c == CH_MINUS || c == CH_DOT)
      c = CH_SPACE;
    return c;
  endfunction

  function automatic logic [7:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CH_PLUS;
    if (r < 75) return CH_MINUS;
    return CH_DOT;
  endfunction

  // Well-formed expression with random content; a few operators land on a short stack.
  task automatic build_expr_line();
    int tokens, live, r, nd_max;
    bit after_num;
    logic [7:0] op;
    tokens    = $urandom_range(2, 24);
    live      = 0;
    after_num = 1'b0;
    repeat (tokens) begin
      r = $urandom_range(0, 99);
      if ((live < 2 && r < 85) || (live >= 2 && r < 40)) begin
        if (after_num) line_chars.push_back(separator());
        r      = $urandom_range(0, 9);
        nd_max = (r < 7) ? 3 : (r < 9) ? 9 : 12;
        add_number(nd_max);
        live++;
        after_num = 1'b1;
      end else begin
        op = pick_op();
        line_chars.push_back(op);
        if (op == CH_DOT) begin
          if (live > 0) live--;
        end else if (live > 1) begin
          live--;
        end
        after_num = 1'b0;
      end
    end
    // Close the line on a print, a newline, a digit that gets dropped, or any byte.
    r = $urandom_range(0, 99);
    if (r < 50)      line_chars.push_back(CH_DOT);
    else if (r < 70) line_chars.push_back(CH_NEWLINE);
    else if (r < 85) line_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    else             line_chars.push_back(8'($urandom_range(0, 255)));
  endtask

  // Push the stack to around full so pushes start to overflow, then use the top.
  task automatic build_deep_line();
    int n;
    n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
    repeat (n) begin
      add_number(2);
      line_chars.push_back(CH_SPACE);
    end
    add_number(2);
    line_chars.push_back(pick_op());
    line_chars.push_back(CH_DOT);
    line_chars.push_back(CH_MINUS);
    line_chars.push_back(CH_DOT);
  endtask

  task automatic build_noise_line();
    int n;
    n = $urandom_range(1, 20);
    repeat (n) line_chars.push_back(8'($urandom_range(0, 255)));
  endtask

  // Result side: take beats, stall at random, and serve a long hold when asked.
  initial begin
    int stall_left;
    stall_left = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready)
        calc.check_result(results_if.value, results_if.kind);
      if (rx_hold_cycles > 0) begin
        stall_left     = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (rst) begin
        results_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        results_if.ready <= 1'b0;
        stall_left--;
      end else begin
        results_if.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = idle_span();
      end
    end
  end

  initial begin
    int line_no;
    calc           = new();
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    rx_hold_cycles = 0;
    rand_sent      = 0;
    rst                  <= 1'b1;
    chars_if.valid       <= 1'b0;
    chars_if.char_code   <= '0;
    chars_if.end_of_line <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: print on an empty stack, binary op on one entry, add and subtract
    // order, a number that wraps past 32 bits, a digit that ends its line and is
    // dropped, and the byte extremes as plain terminators.
    send_text(".", 1'b0);
    send_text("9-", 1'b0);
    send_text("0+.", 1'b0);
    send_text("3 5-.", 1'b0);
    send_text("5000000000.", 1'b0);
    send_text("7", 1'b1);
    send_text(".", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    wait_drain(DRAIN_LIMIT);

    // Pressure: hold results off for a long stretch while prints keep coming, so the
    // result queue fills and the block stalls its input; then drain completely.
    tx_calm        = 1'b1;
    rx_hold_cycles = HOLD_CYCLES;
    send_text("1.2.3.4.5.6.7.8.9.0.11.22.33.44.55.", 1'b1);
    wait_drain(DRAIN_LIMIT);

    // Random lines: mostly expressions, a couple near the stack limit, some noise.
    line_no   = 0;
    rand_sent = 0;
    while (rand_sent < RANDOM_CHARS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      if (line_no % 50 == 10)
        build_deep_line();
      else if ($urandom_range(0, 9) < 8)
        build_expr_line();
      else
        build_noise_line();
      send_line();
      line_no++;
    end

    wait_drain(DRAIN_LIMIT);
    repeat (20) @(posedge clk);
    if (calc.due_results.size() != 0) begin
      $error("%0d expected results never arrived", calc.due_results.size());
      calc.errors++;
    end
    $display("Covered %0d characters over %0d lines", calc.chars_seen, calc.lines_seen);
    $display("Results: %0d printed values, %0d underflows, %0d overflows",
             calc.prints, calc.underflows, calc.overflows);
    if (calc.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
